@@ sv/temp_sensor_frame_check_cache_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the temperature sensor frame check and cache unit
// ----------------------------------------------------------------------------
`ifndef TEMP_SENSOR_FRAME_CHECK_CACHE_UNIT_DEFINES_SVH
`define TEMP_SENSOR_FRAME_CHECK_CACHE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TSFC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsfc: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define TSFC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsfc: next-cycle check failed");

`endif

@@ sv/tsfc_pkg.sv @@
// ----------------------------------------------------------------------------
// tsfc_pkg
// Shared types, codes and helpers for the sensor frame check and cache unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsfc_pkg;

    typedef enum logic [1:0] {
        OP_READ = 2'd0,
        OP_BYTE = 2'd1,
        OP_TICK = 2'd2,
        OP_FAIL = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_TEMP     = 2'd0,
        KIND_CMD      = 2'd1,
        KIND_CRC_ERR  = 2'd2,
        KIND_NO_DATA  = 2'd3
    } kind_t;

    localparam logic [7:0]         MEASURE_CMD = 8'hFD;
    localparam logic [7:0]         CRC_POLY    = 8'h31;
    localparam logic [7:0]         CRC_START   = 8'hFF;
    localparam logic [14:0]        TICK_SCALE  = 15'd21875;
    localparam int                 TICK_SHIFT  = 13;
    localparam logic signed [18:0] TEMP_OFFSET = 19'sd45000;
    localparam logic signed [17:0] TEMP_LOW    = -18'sd40000;
    localparam logic signed [17:0] TEMP_HIGH   = 18'sd125000;
    localparam logic [15:0]        POLL_RESET  = 16'd2000;
    localparam logic [16:0]        AGE_MAX     = 17'h1FFFF;

    typedef struct packed {
        logic               crc_ok;
        logic signed [17:0] temp_raw;
    } conv_t;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic signed [17:0] clamp_temp(input logic signed [17:0] t);
        logic signed [17:0] r;
        r = t;
        if (t < TEMP_LOW)
        begin
            r = TEMP_LOW;
        end
        else if (t > TEMP_HIGH)
        begin
            r = TEMP_HIGH;
        end
        return r;
    endfunction

endpackage

@@ sv/tsfc_convert.sv @@
// ----------------------------------------------------------------------------
// tsfc_convert
// Checks the last reply byte against the running CRC and converts the tick
// word to millidegrees: ((21875 * ticks) >> 13) - 45000.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsfc_convert (
    input  logic [7:0]      crc_in,
    input  logic [7:0]      check_byte,
    input  logic [15:0]     ticks,
    output tsfc_pkg::conv_t conv
);
    import tsfc_pkg::*;

    logic [30:0]        product;
    logic [17:0]        scaled;
    logic signed [18:0] diff;

    assign product = 31'(ticks) * 31'(TICK_SCALE);
    assign scaled  = product[30:TICK_SHIFT];
    assign diff    = $signed({1'b0, scaled}) - TEMP_OFFSET;

    // range is -45000..129997, fits 18 bits signed
    assign conv.temp_raw = diff[17:0];
    assign conv.crc_ok   = (crc_in == check_byte);

endmodule

@@ sv/temp_sensor_frame_check_cache_unit.sv @@
// ----------------------------------------------------------------------------
// temp_sensor_frame_check_cache_unit
// Host side of a temperature sensor read: cache with age check, measure
// command, three-byte reply collection with CRC-8 check and conversion.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+-------------------------------------
//  s_       | in  | s_tvalid/s_tready | tdata: reply_byte; tuser: op
//  m_       | out | m_tvalid/m_tready | tdata: temp_milli, command_byte;
//           |     |                   | tuser: kind
//  cfg_     | in  | cfg_valid/ready   | cfg_data: poll_interval
//
//  One request per cycle sustained while the output is not stalled; each request
//  is held in the input register and leaves its result, if any, in the output register.
//  The conversion multiply and the CRC step sit between those two registers.
//  A stalled output holds the request in the input register; the input register
//  still takes a new request whenever it is empty.
//  Reset (rst_n low) clears all control state; poll_interval returns to 2000.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "temp_sensor_frame_check_cache_unit_defines.svh"

module temp_sensor_frame_check_cache_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] reply_byte
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [17:0] temp_milli, [25:18] command_byte, rest zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // [15:0] poll_interval
);
    import tsfc_pkg::*;

    // input register
    logic               in_valid_reg;
    op_t                in_op_reg;
    logic [7:0]         in_byte_reg;

    // block state
    logic [15:0]        poll_reg;
    logic [1:0]         byte_idx_reg, byte_idx_next;
    logic [7:0]         high_byte_reg, high_byte_next;
    logic [7:0]         low_byte_reg, low_byte_next;
    logic [7:0]         crc_reg, crc_next;
    logic               awaiting_reg, awaiting_next;
    logic               cache_valid_reg, cache_valid_next;
    logic [16:0]        age_reg, age_next;
    logic signed [17:0] cached_reg, cached_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    kind_t              out_kind_reg, out_kind_next;
    logic signed [17:0] out_temp_reg, out_temp_next;
    logic [7:0]         out_cmd_reg, out_cmd_next;

    logic               fire;
    logic               has_result;
    conv_t              conv;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    tsfc_convert u_convert (
        .crc_in     (crc_reg),
        .check_byte (in_byte_reg),
        .ticks      ({high_byte_reg, low_byte_reg}),
        .conv       (conv)
    );

    always_comb
    begin
        byte_idx_next    = byte_idx_reg;
        high_byte_next   = high_byte_reg;
        low_byte_next    = low_byte_reg;
        crc_next         = crc_reg;
        awaiting_next    = awaiting_reg;
        cache_valid_next = cache_valid_reg;
        age_next         = age_reg;
        cached_next      = cached_reg;
        has_result       = 1'b0;
        out_kind_next    = KIND_TEMP;
        out_cmd_next     = 8'h00;
        out_temp_next    = '0;

        if (fire)
        begin
            unique case (in_op_reg)
                OP_READ:
                begin
                    has_result = 1'b1;
                    if (cache_valid_reg && (age_reg <= {1'b0, poll_reg}))
                    begin
                        out_kind_next = KIND_TEMP;
                        out_temp_next = clamp_temp(cached_reg);
                    end
                    else
                    begin
                        // reissue the command and restart collection
                        awaiting_next = 1'b1;
                        byte_idx_next = 2'd0;
                        out_kind_next = KIND_CMD;
                        out_cmd_next  = MEASURE_CMD;
                    end
                end
                OP_TICK:
                begin
                    if (age_reg != AGE_MAX)
                    begin
                        age_next = age_reg + 17'd1;
                    end
                end
                OP_FAIL:
                begin
                    if (awaiting_reg)
                    begin
                        awaiting_next = 1'b0;
                        byte_idx_next = 2'd0;
                        has_result    = 1'b1;
                        out_kind_next = KIND_NO_DATA;
                    end
                end
                OP_BYTE:
                begin
                    if (awaiting_reg)
                    begin
                        priority if (byte_idx_reg == 2'd0)
                        begin
                            high_byte_next = in_byte_reg;
                            crc_next       = crc8_byte(CRC_START, in_byte_reg);
                            byte_idx_next  = 2'd1;
                        end
                        else if (byte_idx_reg == 2'd1)
                        begin
                            low_byte_next = in_byte_reg;
                            crc_next      = crc8_byte(crc_reg, in_byte_reg);
                            byte_idx_next = 2'd2;
                        end
                        else
                        begin
                            awaiting_next = 1'b0;
                            byte_idx_next = 2'd0;
                            has_result    = 1'b1;
                            if (conv.crc_ok)
                            begin
                                cached_next      = conv.temp_raw;
                                cache_valid_next = 1'b1;
                                age_next         = '0;
                                out_kind_next    = KIND_TEMP;
                                out_temp_next    = clamp_temp(conv.temp_raw);
                            end
                            else
                            begin
                                out_kind_next = KIND_CRC_ERR;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (fire && has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            poll_reg        <= POLL_RESET;
            byte_idx_reg    <= '0;
            high_byte_reg   <= '0;
            low_byte_reg    <= '0;
            crc_reg         <= '0;
            awaiting_reg    <= 1'b0;
            cache_valid_reg <= 1'b0;
            age_reg         <= '0;
            cached_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                poll_reg <= cfg_data;
            end
            byte_idx_reg    <= byte_idx_next;
            high_byte_reg   <= high_byte_next;
            low_byte_reg    <= low_byte_next;
            crc_reg         <= crc_next;
            awaiting_reg    <= awaiting_next;
            cache_valid_reg <= cache_valid_next;
            age_reg         <= age_next;
            cached_reg      <= cached_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= op_t'(s_tuser);
            in_byte_reg <= s_tdata;
        end
        if (fire && has_result)
        begin
            out_kind_reg <= out_kind_next;
            out_temp_reg <= out_temp_next;
            out_cmd_reg  <= out_cmd_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {6'd0, out_cmd_reg, out_temp_reg};

    // a read request always leaves a result behind
    `TSFC_ASSERT_NEXT(a_read_gives_result, fire && (in_op_reg == OP_READ), out_valid_reg)
    // collection progress only exists while a reply is pending
    `TSFC_ASSERT_NOW(a_idle_index_zero, !awaiting_reg, byte_idx_reg == 2'd0)
    // a pending command result means a reply is still awaited
    `TSFC_ASSERT_NOW(a_cmd_awaits, out_valid_reg && (out_kind_reg == KIND_CMD), awaiting_reg)

endmodule

@@ tb/temp_reading_checker.sv @@
// ----------------------------------------------------------------------------
// temp_reading_checker
// Watches the request, response and poll-interval channels of the sensor
// frame check and cache unit. It keeps its own copy of the cache, age and
// reply collection state, predicts the response of every accepted request
// and compares each accepted response field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module temp_reading_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] reply_byte
    input  logic [1:0]  s_tuser,   // [1:0] op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [17:0] temp_milli, [25:18] command_byte
    input  logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,  // [15:0] poll_interval
    output int          mismatches,
    output int          outstanding
);
    import tsfc_pkg::*;

    localparam logic [7:0]         MEASURE_BYTE   = 8'hFD;
    localparam logic [7:0]         CRC8_POLY      = 8'h31;
    localparam logic [7:0]         CRC8_SEED      = 8'hFF;
    localparam int                 SCALE_NUM      = 21875;
    localparam int                 SCALE_SHIFT    = 13;
    localparam int                 ZERO_OFFSET    = 45000;
    localparam logic signed [17:0] MILLI_MIN      = -18'sd40000;
    localparam logic signed [17:0] MILLI_MAX      = 18'sd125000;
    localparam logic [15:0]        FRESH_AT_RESET = 16'd2000;
    localparam logic [16:0]        AGE_CEILING    = 17'h1FFFF;

    typedef struct packed {
        kind_t              kind;
        logic signed [17:0] temp_milli;
        logic [7:0]         command_byte;
    } sensor_response_t;

    sensor_response_t   awaited_responses[$];
    logic [15:0]        fresh_limit;
    logic [1:0]         bytes_seen;
    logic [7:0]         word_hi;
    logic [7:0]         word_lo;
    logic               reply_pending;
    logic               have_reading;
    logic [16:0]        reading_age;
    logic signed [17:0] last_reading;
    int                 fail_count;

    // shift the byte in one bit at a time, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        r = acc;
        for (int i = 7; i >= 0; i--)
        begin
            if (r[7] ^ data[i])
                r = {r[6:0], 1'b0} ^ CRC8_POLY;
            else
                r = {r[6:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic signed [17:0] ticks_to_milli(input logic [15:0] ticks);
        logic [31:0] product;
        int          milli;
        product = SCALE_NUM * ticks;
        milli   = int'(product >> SCALE_SHIFT) - ZERO_OFFSET;
        return milli[17:0];
    endfunction

    function automatic logic signed [17:0] clamp_milli(input logic signed [17:0] t);
        if (t < MILLI_MIN)
            return MILLI_MIN;
        if (t > MILLI_MAX)
            return MILLI_MAX;
        return t;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("%0t ns  reading check: %s", $time, what);
        fail_count++;
    endtask

    task automatic await_response(input kind_t k, input logic signed [17:0] t,
                                  input logic [7:0] c);
        sensor_response_t r;
        r.kind         = k;
        r.temp_milli   = t;
        r.command_byte = c;
        awaited_responses.push_back(r);
    endtask

    task automatic predict_request(input op_t op, input logic [7:0] b);
        case (op)
            OP_READ:
            begin
                if (have_reading && reading_age <= {1'b0, fresh_limit})
                begin
                    await_response(KIND_TEMP, clamp_milli(last_reading), 8'h00);
                end
                else
                begin
                    reply_pending = 1'b1;
                    bytes_seen    = 2'd0;
                    await_response(KIND_CMD, 18'sd0, MEASURE_BYTE);
                end
            end
            OP_TICK:
            begin
                if (reading_age != AGE_CEILING)
                    reading_age = reading_age + 17'd1;
            end
            OP_FAIL:
            begin
                if (reply_pending)
                begin
                    reply_pending = 1'b0;
                    bytes_seen    = 2'd0;
                    await_response(KIND_NO_DATA, 18'sd0, 8'h00);
                end
            end
            default:
            begin
                // reply bytes count only while a reply is pending
                if (reply_pending)
                begin
                    if (bytes_seen == 2'd0)
                    begin
                        word_hi    = b;
                        bytes_seen = 2'd1;
                    end
                    else if (bytes_seen == 2'd1)
                    begin
                        word_lo    = b;
                        bytes_seen = 2'd2;
                    end
                    else
                    begin
                        reply_pending = 1'b0;
                        bytes_seen    = 2'd0;
                        if (crc8_step(crc8_step(CRC8_SEED, word_hi), word_lo) != b)
                        begin
                            await_response(KIND_CRC_ERR, 18'sd0, 8'h00);
                        end
                        else
                        begin
                            last_reading = ticks_to_milli({word_hi, word_lo});
                            have_reading = 1'b1;
                            reading_age  = 17'd0;
                            await_response(KIND_TEMP, clamp_milli(last_reading), 8'h00);
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic check_response();
        sensor_response_t want;
        if (awaited_responses.size() == 0)
        begin
            flag_mismatch($sformatf("response kind %0d with none awaited", m_tuser));
        end
        else
        begin
            want = awaited_responses.pop_front();
            if (m_tuser != want.kind)
                flag_mismatch($sformatf("kind got %0d want %0d", m_tuser, want.kind));
            if ($signed(m_tdata[17:0]) != want.temp_milli)
                flag_mismatch($sformatf("temp_milli got %0d want %0d",
                                        $signed(m_tdata[17:0]), want.temp_milli));
            if (m_tdata[25:18] != want.command_byte)
                flag_mismatch($sformatf("command_byte got %h want %h",
                                        m_tdata[25:18], want.command_byte));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited_responses.delete();
            fresh_limit   = FRESH_AT_RESET;
            bytes_seen    = 2'd0;
            word_hi       = 8'h00;
            word_lo       = 8'h00;
            reply_pending = 1'b0;
            have_reading  = 1'b0;
            reading_age   = 17'd0;
            last_reading  = 18'sd0;
            fail_count    = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                fresh_limit = cfg_data;
            // a response always stems from an earlier request: pop before push
            if (m_tvalid && m_tready)
                check_response();
            if (s_tvalid && s_tready)
                predict_request(op_t'(s_tuser), s_tdata);
            outstanding <= awaited_responses.size();
            mismatches  <= fail_count;
        end
    end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the sensor frame check and cache unit: directed
// requests over the cache, reply, checksum and failure paths, then random
// request mixes under several poll intervals, mostly with random source gaps and
// sink stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import tsfc_pkg::*;

    // about 1100 requests, each possibly behind a source gap and a sink stall
    localparam int CYCLE_LIMIT   = 200000;
    // two pipeline stages plus margin
    localparam int SETTLE_CYCLES = 4;
    localparam int MIX_ITEMS     = 200;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h00;
    logic [1:0]  s_tuser     = OP_READ;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data    = 16'd0;

    logic        stall_enable = 1'b0;
    int unsigned stall_left   = 0;
    int unsigned cycle_count  = 0;
    bit          sender_gaps  = 1'b0;
    int          mismatches;
    int          outstanding;

    temp_sensor_frame_check_cache_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    temp_reading_checker reading_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[temp_sensor_frame_check_cache_unit] ERROR");
            $finish;
        end
    end

    // sink stalls: m_tready dropped at random while stall_enable is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if (stall_enable && $urandom_range(0, 4) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic push_request(input op_t op, input logic [7:0] b);
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic push_ticks(input int unsigned n);
        repeat (n) push_request(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    // three reply bytes, ticks slipped in between now and then
    task automatic send_frame(input logic [15:0] ticks, input bit corrupt);
        logic [7:0] check;
        check = crc8_byte(crc8_byte(CRC_START, ticks[15:8]), ticks[7:0]);
        if (corrupt)
            check = check ^ 8'($urandom_range(1, 255));
        push_request(OP_BYTE, ticks[15:8]);
        if ($urandom_range(0, 7) == 0)
            push_ticks($urandom_range(1, 2));
        push_request(OP_BYTE, ticks[7:0]);
        if ($urandom_range(0, 7) == 0)
            push_ticks(1);
        push_request(OP_BYTE, check);
    endtask

    // mostly uniform, sometimes the ends of the range and the clamp edges
    function automatic logic [15:0] pick_ticks();
        case ($urandom_range(0, 15))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'(1872 + $urandom_range(0, 2));
            3:       return 16'(63662 + $urandom_range(0, 3));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_poll(input logic [15:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_mix(input int unsigned count, input bit allow_gaps);
        int unsigned sent;
        int unsigned pick;
        int unsigned k;
        sent = 0;
        while (sent < count)
        begin
            if (allow_gaps && $urandom_range(0, 19) == 0)
            begin
                sender_gaps = ($urandom_range(0, 2) != 0);
                stall_enable <= sender_gaps;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                push_request(OP_READ, 8'($urandom_range(0, 255)));
                send_frame(pick_ticks(), 1'b0);
                sent += 4;
            end
            else if (pick < 55)
            begin
                push_request(OP_READ, 8'($urandom_range(0, 255)));
                send_frame(pick_ticks(), 1'b1);
                sent += 4;
            end
            else if (pick < 65)
            begin
                // broken frame: cut short by a bus failure
                k = $urandom_range(0, 2);
                push_request(OP_READ, 8'($urandom_range(0, 255)));
                repeat (k) push_request(OP_BYTE, 8'($urandom_range(0, 255)));
                push_request(OP_FAIL, 8'($urandom_range(0, 255)));
                sent += 2 + k;
            end
            else if (pick < 85)
            begin
                k = $urandom_range(1, 12);
                push_ticks(k);
                sent += k;
            end
            else
            begin
                push_request(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                sent += 1;
            end
        end
    endtask

    initial
    begin
        sender_gaps = 1'b1;
        stall_enable <= 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // idle bytes and failures, then an empty cache and the low clamp
        push_request(OP_BYTE, 8'h55);
        push_request(OP_FAIL, 8'hAA);
        push_request(OP_READ, 8'h00);
        send_frame(16'h0000, 1'b0);
        push_request(OP_READ, 8'hFF);

        // stale after one tick; a read mid-reply restarts collection
        write_poll(16'd0);
        push_request(OP_READ, 8'h00);
        push_request(OP_TICK, 8'h00);
        push_request(OP_READ, 8'h00);
        push_request(OP_BYTE, 8'h12);
        push_request(OP_READ, 8'h00);
        send_frame(16'hFFFF, 1'b0);
        push_request(OP_TICK, 8'hFF);
        push_request(OP_READ, 8'h00);
        send_frame(16'h6666, 1'b1);
        push_request(OP_READ, 8'h00);
        push_request(OP_BYTE, 8'h01);
        push_request(OP_BYTE, 8'h02);
        push_request(OP_FAIL, 8'h00);
        push_request(OP_FAIL, 8'h00);

        // checksum error left the cache alone; age right at the interval
        write_poll(16'd5);
        push_request(OP_READ, 8'h00);
        push_ticks(4);
        push_request(OP_READ, 8'h00);
        push_request(OP_TICK, 8'h00);
        push_request(OP_READ, 8'h00);
        send_frame(16'h7A3C, 1'b0);

        write_poll(16'd30);
        run_mix(MIX_ITEMS, 1'b1);
        write_poll(16'd0);
        run_mix(MIX_ITEMS, 1'b1);
        write_poll(16'hFFFF);
        run_mix(MIX_ITEMS, 1'b1);
        write_poll(16'd3);
        run_mix(MIX_ITEMS, 1'b1);

        // last stretch runs back to back on both sides
        sender_gaps = 1'b0;
        stall_enable <= 1'b0;
        write_poll(16'($urandom_range(0, 40)));
        run_mix(MIX_ITEMS, 1'b0);

        settle();
        if (mismatches == 0)
            $display("[temp_sensor_frame_check_cache_unit] OK");
        else
            $display("[temp_sensor_frame_check_cache_unit] ERROR");
        $finish;
    end

endmodule

@@ temp_sensor_frame_check_cache_unit.f @@
+incdir+sv
sv/tsfc_pkg.sv
sv/tsfc_convert.sv
sv/temp_sensor_frame_check_cache_unit.sv
tb/temp_reading_checker.sv
tb/tb_top.sv
